FILE: rtl/abb_pkg.sv
// shared types and constants for the active pixel bounding box
// no dependencies
`default_nettype none

package abb_pkg;

   localparam int PIXEL_W  = 8;
   localparam int FRAME_W  = 11;
   localparam int MARGIN_W = 10;
   localparam int OUT_W    = 11;
   localparam int DATA_W   = 32;
   localparam int ADDR_W   = 5;
   localparam int INDEX_W  = 3;

   localparam logic [FRAME_W-1:0] FRAME_RESET = 11'd1024;

   typedef enum logic [INDEX_W-1:0] {
      REG_FRAME_WIDTH   = 3'd0,
      REG_FRAME_HEIGHT  = 3'd1,
      REG_MARGIN_LEFT   = 3'd2,
      REG_MARGIN_RIGHT  = 3'd3,
      REG_MARGIN_TOP    = 3'd4,
      REG_MARGIN_BOTTOM = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [FRAME_W-1:0]  frame_width;
      logic [FRAME_W-1:0]  frame_height;
      logic [MARGIN_W-1:0] margin_left_px;
      logic [MARGIN_W-1:0] margin_right_px;
      logic [MARGIN_W-1:0] margin_top_px;
      logic [MARGIN_W-1:0] margin_bottom_px;
   } cfg_type;

endpackage

`default_nettype wire

FILE: rtl/abb_if.sv
// valid/ready channel interfaces for pixels in and boxes out
// depends on abb_pkg
`default_nettype none

interface abb_req_if;
   import abb_pkg::*;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_value;
   modport source (output valid, output pixel_value, input ready);
   modport sink (input valid, input pixel_value, output ready);
endinterface

interface abb_rsp_if;
   import abb_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [OUT_W-1:0]        box_left;
   logic [OUT_W-1:0]        box_top;
   logic signed [OUT_W-1:0] box_width;
   logic signed [OUT_W-1:0] box_height;
   modport source (output valid, output box_left, output box_top, output box_width,
                   output box_height, input ready);
   modport sink (input valid, input box_left, input box_top, input box_width,
                 input box_height, output ready);
endinterface

`default_nettype wire

FILE: rtl/abb_csr.sv
// apb-style configuration registers for frame size and window margins
// depends on abb_pkg
`default_nettype none

module abb_csr (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [abb_pkg::ADDR_W-1:0] paddr,
   input  wire logic [abb_pkg::DATA_W-1:0] pwdata,
   output logic      [abb_pkg::DATA_W-1:0] prdata,
   output logic                           pready,
   output abb_pkg::cfg_type               cfg
);
   import abb_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index  = reg_index_type'(paddr[ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_FRAME_WIDTH:   cfg_in.frame_width      = pwdata[FRAME_W-1:0];
            REG_FRAME_HEIGHT:  cfg_in.frame_height     = pwdata[FRAME_W-1:0];
            REG_MARGIN_LEFT:   cfg_in.margin_left_px   = pwdata[MARGIN_W-1:0];
            REG_MARGIN_RIGHT:  cfg_in.margin_right_px  = pwdata[MARGIN_W-1:0];
            REG_MARGIN_TOP:    cfg_in.margin_top_px    = pwdata[MARGIN_W-1:0];
            REG_MARGIN_BOTTOM: cfg_in.margin_bottom_px = pwdata[MARGIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_FRAME_WIDTH:   prdata = DATA_W'(cfg_ff.frame_width);
         REG_FRAME_HEIGHT:  prdata = DATA_W'(cfg_ff.frame_height);
         REG_MARGIN_LEFT:   prdata = DATA_W'(cfg_ff.margin_left_px);
         REG_MARGIN_RIGHT:  prdata = DATA_W'(cfg_ff.margin_right_px);
         REG_MARGIN_TOP:    prdata = DATA_W'(cfg_ff.margin_top_px);
         REG_MARGIN_BOTTOM: prdata = DATA_W'(cfg_ff.margin_bottom_px);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width      <= FRAME_RESET;
         cfg_ff.frame_height     <= FRAME_RESET;
         cfg_ff.margin_left_px   <= '0;
         cfg_ff.margin_right_px  <= '0;
         cfg_ff.margin_top_px    <= '0;
         cfg_ff.margin_bottom_px <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/active_pixel_bounding_box.sv
// bounding box of set pixels: one pixel per clock, one box per frame
// path: an accepted pixel is held in the input register until it is consumed; the box of a
// frame is registered in the result register when the frame's last pixel is consumed
// throughput: one pixel per cycle; the input stalls only while a frame's last pixel waits
// for an earlier box that has not been taken
// reset: synchronous; clears raster position, running extremes, both stages and the
// registers (frame sizes to 1024, margins to 0)
`default_nettype none

module active_pixel_bounding_box #(
   parameter int MAX_DIM = 1024
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   abb_req_if.sink                        req,
   abb_rsp_if.source                      rsp,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [abb_pkg::ADDR_W-1:0] paddr,
   input  wire logic [abb_pkg::DATA_W-1:0] pwdata,
   output logic      [abb_pkg::DATA_W-1:0] prdata,
   output logic                           pready
);
   import abb_pkg::*;

   localparam int POS_W = $clog2(MAX_DIM);
   localparam int EXT_W = $clog2(MAX_DIM + 1);
   localparam int CW    = ((EXT_W > FRAME_W) ? EXT_W : FRAME_W) + 2;

   typedef logic signed [CW-1:0] calc_type;

   function automatic calc_type smin(input calc_type a, input calc_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic calc_type smax(input calc_type a, input calc_type b);
      return (a > b) ? a : b;
   endfunction

   cfg_type cfg;

   logic [PIXEL_W-1:0] pix_ff;
   logic [PIXEL_W-1:0] pix_in;
   logic               pix_vld_ff;
   logic               pix_vld_in;
   logic               req_take;
   logic               consume;

   logic [POS_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [EXT_W-1:0] top_min_ff, top_min_in, left_min_ff, left_min_in;
   logic [POS_W-1:0] bot_max_ff, bot_max_in, right_max_ff, right_max_in;

   logic                    rsp_vld_ff, rsp_vld_in;
   logic [OUT_W-1:0]        left_ff, left_in, top_ff, top_in;
   logic signed [OUT_W-1:0] width_ff, width_in, height_ff, height_in;

   logic [CW-1:0] w_u, h_u;
   calc_type w_s, h_s, ml_s, mr_s, mt_s, mb_s, xl_s, yl_s, x_s, y_s;
   calc_type top_s, bot_s, left_s, right_s;
   calc_type top_new, bot_new, left_new, right_new;
   calc_type top_r, bot_r, left_r, right_r, width_r, height_r;
   logic     set, in_cols, upd_top, upd_bot, upd_left, upd_right;
   logic     last_col, last_row, frame_end;

   abb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // frame size saturated into [1, MAX_DIM]
   assign w_u = CW'(cfg.frame_width);
   assign h_u = CW'(cfg.frame_height);

   always_comb begin
      if (w_u == '0) begin
         w_s = calc_type'(1);
      end else if (w_u > CW'(MAX_DIM)) begin
         w_s = calc_type'(MAX_DIM);
      end else begin
         w_s = signed'(w_u);
      end
      if (h_u == '0) begin
         h_s = calc_type'(1);
      end else if (h_u > CW'(MAX_DIM)) begin
         h_s = calc_type'(MAX_DIM);
      end else begin
         h_s = signed'(h_u);
      end
   end

   assign ml_s = signed'(CW'(cfg.margin_left_px));
   assign mr_s = signed'(CW'(cfg.margin_right_px));
   assign mt_s = signed'(CW'(cfg.margin_top_px));
   assign mb_s = signed'(CW'(cfg.margin_bottom_px));
   assign xl_s = w_s - ml_s - mr_s;
   assign yl_s = h_s - mt_s - mb_s;

   assign x_s     = signed'(CW'(x_ff));
   assign y_s     = signed'(CW'(y_ff));
   assign top_s   = signed'(CW'(top_min_ff));
   assign bot_s   = signed'(CW'(bot_max_ff));
   assign left_s  = signed'(CW'(left_min_ff));
   assign right_s = signed'(CW'(right_max_ff));

   assign set       = (pix_ff != '0);
   assign in_cols   = (x_s >= ml_s) && (x_s < xl_s);
   assign upd_top   = set && in_cols && (y_s >= mt_s) && (y_s < yl_s) && (y_s < top_s);
   assign upd_bot   = set && in_cols && (y_s > mt_s) && (y_s < yl_s) && (y_s > bot_s);
   assign upd_left  = set && in_cols && (x_s < left_s);
   assign upd_right = set && (x_s > ml_s) && (x_s < xl_s) && (x_s > right_s);

   assign top_new   = upd_top ? y_s : top_s;
   assign bot_new   = upd_bot ? y_s : bot_s;
   assign left_new  = upd_left ? x_s : left_s;
   assign right_new = upd_right ? x_s : right_s;

   assign last_col  = (x_s + calc_type'(1)) >= w_s;
   assign last_row  = (y_s + calc_type'(1)) >= h_s;
   assign frame_end = last_col && last_row;

   always_comb begin
      if (xl_s > ml_s) begin
         top_r = smin(h_s, smin(top_new, smax(mt_s, yl_s)));
         bot_r = smax('0, smax(bot_new, smin(mt_s, yl_s - calc_type'(1))));
      end else begin
         top_r = h_s;
         bot_r = '0;
      end
      left_r   = smin(w_s, smin(left_new, smax(ml_s, xl_s)));
      right_r  = smax('0, smax(right_new, smin(ml_s, xl_s - calc_type'(1))));
      width_r  = right_r - left_r;
      height_r = bot_r - top_r;
   end

   // handshake between input register and result register
   assign consume    = pix_vld_ff && (!frame_end || !rsp_vld_ff || rsp.ready);
   assign req.ready  = !pix_vld_ff || consume;
   assign req_take   = req.valid && req.ready;
   assign pix_vld_in = req_take || (pix_vld_ff && !consume);
   assign pix_in     = req_take ? req.pixel_value : pix_ff;

   always_comb begin
      x_in         = x_ff;
      y_in         = y_ff;
      top_min_in   = top_min_ff;
      bot_max_in   = bot_max_ff;
      left_min_in  = left_min_ff;
      right_max_in = right_max_ff;
      if (consume) begin
         if (frame_end) begin
            x_in         = '0;
            y_in         = '0;
            top_min_in   = EXT_W'(MAX_DIM);
            bot_max_in   = '0;
            left_min_in  = EXT_W'(MAX_DIM);
            right_max_in = '0;
         end else begin
            top_min_in   = EXT_W'(top_new);
            bot_max_in   = POS_W'(bot_new);
            left_min_in  = EXT_W'(left_new);
            right_max_in = POS_W'(right_new);
            if (last_col) begin
               x_in = '0;
               y_in = POS_W'(y_s + calc_type'(1));
            end else begin
               x_in = POS_W'(x_s + calc_type'(1));
            end
         end
      end
   end

   assign rsp_vld_in = (consume && frame_end) || (rsp_vld_ff && !rsp.ready);
   assign left_in    = (consume && frame_end) ? left_r[OUT_W-1:0] : left_ff;
   assign top_in     = (consume && frame_end) ? top_r[OUT_W-1:0] : top_ff;
   assign width_in   = (consume && frame_end) ? signed'(width_r[OUT_W-1:0]) : width_ff;
   assign height_in  = (consume && frame_end) ? signed'(height_r[OUT_W-1:0]) : height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_vld_ff   <= 1'b0;
         rsp_vld_ff   <= 1'b0;
         x_ff         <= '0;
         y_ff         <= '0;
         top_min_ff   <= EXT_W'(MAX_DIM);
         bot_max_ff   <= '0;
         left_min_ff  <= EXT_W'(MAX_DIM);
         right_max_ff <= '0;
      end else begin
         pix_vld_ff   <= pix_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         top_min_ff   <= top_min_in;
         bot_max_ff   <= bot_max_in;
         left_min_ff  <= left_min_in;
         right_max_ff <= right_max_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff    <= pix_in;
      left_ff   <= left_in;
      top_ff    <= top_in;
      width_ff  <= width_in;
      height_ff <= height_in;
   end

   assign rsp.valid      = rsp_vld_ff;
   assign rsp.box_left   = left_ff;
   assign rsp.box_top    = top_ff;
   assign rsp.box_width  = width_ff;
   assign rsp.box_height = height_ff;

endmodule

`default_nettype wire

FILE: rtl/abb_checker.sv
// port-level checks for the bounding box block, bound to the top level
// depends on abb_pkg and active_pixel_bounding_box
`default_nettype none

module abb_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [abb_pkg::OUT_W-1:0]     rsp_box_left,
   input wire logic [abb_pkg::OUT_W-1:0]     rsp_box_top,
   input wire logic signed [abb_pkg::OUT_W-1:0] rsp_box_width,
   input wire logic signed [abb_pkg::OUT_W-1:0] rsp_box_height
);
   import abb_pkg::*;

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its fields
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_box_left) && $stable(rsp_box_top)
         && $stable(rsp_box_width) && $stable(rsp_box_height))
      else $error("result changed while stalled");

   // a new result follows an accepted pixel, with the input and result registers between them
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a pixel transaction");

endmodule

bind active_pixel_bounding_box abb_checker u_abb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_box_left   (rsp.box_left),
   .rsp_box_top    (rsp.box_top),
   .rsp_box_width  (rsp.box_width),
   .rsp_box_height (rsp.box_height)
);

`default_nettype wire

FILE: tb/active_pixel_bounding_box_tb.sv
// self-checking testbench for active_pixel_bounding_box: directed frames and random frames under many
// register settings, each box compared field by field with a predictor kept in the bench
// depends on abb_pkg, abb_if and the rtl of the block
module active_pixel_bounding_box_tb;
   import abb_pkg::*;

   localparam int MAX_DIM        = 1024;
   localparam int RANDOM_PHASES  = 30;
   localparam int PRESSURE_PHASE = 25;
   localparam int PIXEL_BUDGET   = 4;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 6;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int REPORT_LIMIT   = 10;

   typedef enum int {
      STAGE_SLOW_RECEIVER,
      STAGE_SLOW_SENDER,
      STAGE_FREE_RUN
   } idle_stage_type;

   typedef struct packed {
      logic [OUT_W-1:0]        left;
      logic [OUT_W-1:0]        top;
      logic signed [OUT_W-1:0] width;
      logic signed [OUT_W-1:0] height;
   } box_type;

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   abb_req_if req_if();
   abb_rsp_if rsp_if();

   active_pixel_bounding_box #(.MAX_DIM(MAX_DIM)) dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   cfg_type            cfg_shadow;
   int                 col_pos;
   int                 row_pos;
   int                 top_min;
   int                 bottom_max;
   int                 left_min;
   int                 right_max;
   logic [PIXEL_W-1:0] pixel_queue[$];
   box_type            box_expected[$];
   int                 pixels_queued;
   int                 pixels_accepted;
   int                 boxes_checked;
   int                 settings_applied;
   int                 failures;
   int                 sender_idle_pct;
   int                 receiver_idle_pct;
   int                 hold_seq;
   int                 hold_seen;
   int                 hold_left;
   int                 idle_cycles;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int clamp_dim(input logic [FRAME_W-1:0] raw);
      if (raw == '0) return 1;
      if (raw > MAX_DIM) return MAX_DIM;
      return int'(raw);
   endfunction

   function automatic void clear_box_state();
      col_pos    = 0;
      row_pos    = 0;
      top_min    = MAX_DIM;
      bottom_max = 0;
      left_min   = MAX_DIM;
      right_max  = 0;
   endfunction

   // advance the raster position by one pixel; the last pixel of a frame yields a box
   function automatic void track_pixel(input logic [PIXEL_W-1:0] pix);
      int      w, h, ml, mt, xl, yl, x, y, lft, tp, rgt, btm, dx, dy;
      logic    in_cols;
      box_type box;
      w  = clamp_dim(cfg_shadow.frame_width);
      h  = clamp_dim(cfg_shadow.frame_height);
      ml = int'(cfg_shadow.margin_left_px);
      mt = int'(cfg_shadow.margin_top_px);
      xl = w - ml - int'(cfg_shadow.margin_right_px);
      yl = h - mt - int'(cfg_shadow.margin_bottom_px);
      x  = col_pos;
      y  = row_pos;
      if (pix != '0) begin
         in_cols = (x >= ml) && (x < xl);
         if (in_cols && y >= mt && y < yl && y < top_min) top_min = y;
         if (in_cols && y > mt && y < yl && y > bottom_max) bottom_max = y;
         if (in_cols && x < left_min) left_min = x;
         if (x > ml && x < xl && x > right_max) right_max = x;
      end
      if (x + 1 < w) begin
         col_pos = x + 1;
         return;
      end
      col_pos = 0;
      if (y + 1 < h) begin
         row_pos = y + 1;
         return;
      end
      if (xl > ml) begin
         tp = (mt > yl) ? mt : yl;
         if (top_min < tp) tp = top_min;
         if (h < tp) tp = h;
         btm = (mt < yl - 1) ? mt : yl - 1;
         if (bottom_max > btm) btm = bottom_max;
         if (btm < 0) btm = 0;
      end else begin
         tp  = h;
         btm = 0;
      end
      lft = (ml > xl) ? ml : xl;
      if (left_min < lft) lft = left_min;
      if (w < lft) lft = w;
      rgt = (ml < xl - 1) ? ml : xl - 1;
      if (right_max > rgt) rgt = right_max;
      if (rgt < 0) rgt = 0;
      dx = rgt - lft;
      dy = btm - tp;
      box.left   = lft[OUT_W-1:0];
      box.top    = tp[OUT_W-1:0];
      box.width  = dx[OUT_W-1:0];
      box.height = dy[OUT_W-1:0];
      box_expected.push_back(box);
      clear_box_state();
   endfunction

   function automatic void note_failure(input string what, input box_type want,
                                        input box_type got);
      failures++;
      if (failures <= REPORT_LIMIT)
         $display({"%s: expected left %0d top %0d width %0d height %0d,",
                   " got left %0d top %0d width %0d height %0d"},
                  what, want.left, want.top, want.width, want.height,
                  got.left, got.top, got.width, got.height);
   endfunction

   task automatic set_stage(input idle_stage_type stage);
      case (stage)
         STAGE_SLOW_RECEIVER: begin
            sender_idle_pct   = 24;
            receiver_idle_pct = 83;
         end
         STAGE_SLOW_SENDER: begin
            sender_idle_pct   = 83;
            receiver_idle_pct = 24;
         end
         default: begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
      endcase
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [FRAME_W-1:0] value);
      logic [DATA_W-1:0] junk;
      junk = $urandom();
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {junk[DATA_W-1:FRAME_W], value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_FRAME_WIDTH:   cfg_shadow.frame_width      = value;
         REG_FRAME_HEIGHT:  cfg_shadow.frame_height     = value;
         REG_MARGIN_LEFT:   cfg_shadow.margin_left_px   = value[MARGIN_W-1:0];
         REG_MARGIN_RIGHT:  cfg_shadow.margin_right_px  = value[MARGIN_W-1:0];
         REG_MARGIN_TOP:    cfg_shadow.margin_top_px    = value[MARGIN_W-1:0];
         REG_MARGIN_BOTTOM: cfg_shadow.margin_bottom_px = value[MARGIN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input int fw, input int fh, input int ml, input int mr,
                                input int mt, input int mb);
      csr_write(REG_FRAME_WIDTH, fw[FRAME_W-1:0]);
      csr_write(REG_FRAME_HEIGHT, fh[FRAME_W-1:0]);
      csr_write(REG_MARGIN_LEFT, ml[FRAME_W-1:0]);
      csr_write(REG_MARGIN_RIGHT, mr[FRAME_W-1:0]);
      csr_write(REG_MARGIN_TOP, mt[FRAME_W-1:0]);
      csr_write(REG_MARGIN_BOTTOM, mb[FRAME_W-1:0]);
      settings_applied++;
   endtask

   task automatic queue_pixel(input logic [PIXEL_W-1:0] value);
      pixel_queue.push_back(value);
      pixels_queued++;
   endtask

   task automatic queue_frame(input int density);
      int n;
      logic [PIXEL_W-1:0] value;
      n = clamp_dim(cfg_shadow.frame_width) * clamp_dim(cfg_shadow.frame_height);
      repeat (n) begin
         if ($urandom_range(0, 99) < density) value = $urandom_range(1, 255);
         else value = '0;
         queue_pixel(value);
      end
   endtask

   // all pixels taken and every box seen, then a wait for the pipeline to settle
   task automatic wait_for_drain();
      while (pixels_accepted != pixels_queued || box_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : pixel_driver
      if (reset) begin
         req_if.valid       <= 1'b0;
         req_if.pixel_value <= '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            track_pixel(req_if.pixel_value);
            pixels_accepted++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               req_if.valid       <= 1'b1;
               req_if.pixel_value <= pixel_queue.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : box_monitor
      box_type got;
      box_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = {rsp_if.box_left, rsp_if.box_top, rsp_if.box_width, rsp_if.box_height};
            if (box_expected.size() == 0) begin
               note_failure("box with no frame pending", '0, got);
            end else begin
               want = box_expected.pop_front();
               if (got.left !== want.left || got.top !== want.top ||
                   got.width !== want.width || got.height !== want.height)
                  note_failure("box mismatch", want, got);
               boxes_checked++;
            end
         end
         // long hold lets the block fill up and push back on the pixel stream
         if (hold_seq != hold_seen) begin
            hold_seen    <= hold_seq;
            hold_left    <= HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int phase, frames, fw, fh, ml, mr, mt, mb, density;
      reset              <= 1'b1;
      psel               <= 1'b0;
      penable            <= 1'b0;
      pwrite             <= 1'b0;
      paddr              <= '0;
      pwdata             <= '0;
      cfg_shadow              = '0;
      cfg_shadow.frame_width  = FRAME_RESET;
      cfg_shadow.frame_height = FRAME_RESET;
      clear_box_state();
      set_stage(STAGE_SLOW_RECEIVER);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty, full and single-pixel frames, one-pixel frames from zero sizes,
      // and a window inverted by wide margins
      apply_setting(2, 2, 0, 0, 0, 0);
      repeat (4) queue_pixel(8'd0);
      repeat (4) queue_pixel(8'd255);
      queue_pixel(8'd0);
      queue_pixel(8'd0);
      queue_pixel(8'd0);
      queue_pixel(8'd128);
      wait_for_drain();
      apply_setting(0, 0, 0, 0, 0, 0);
      queue_pixel(8'd0);
      queue_pixel(8'd1);
      wait_for_drain();
      apply_setting(3, 2, 2, 2, 1, 2);
      repeat (6) queue_pixel(8'd255);
      wait_for_drain();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_stage(idle_stage_type'(phase * 3 / RANDOM_PHASES));
         if (phase == PRESSURE_PHASE) begin
            apply_setting(2, 2, 0, 0, 0, 0);
            frames = 30;
            hold_seq++;
         end else begin
            fw = $urandom_range(0, 6);
            fh = $urandom_range(0, 6);
            if ($urandom_range(0, 4) == 0) begin
               ml = $urandom_range(0, 1023);
               mr = $urandom_range(0, 1023);
               mt = $urandom_range(0, 1023);
               mb = $urandom_range(0, 1023);
            end else begin
               ml = $urandom_range(0, 3);
               mr = $urandom_range(0, 3);
               mt = $urandom_range(0, 3);
               mb = $urandom_range(0, 3);
            end
            apply_setting(fw, fh, ml, mr, mt, mb);
            frames = 1 + PIXEL_BUDGET /
                     (clamp_dim(fw[FRAME_W-1:0]) * clamp_dim(fh[FRAME_W-1:0]));
         end
         repeat (frames) begin
            density = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5)
                                                  : $urandom_range(0, 100);
            queue_frame(density);
         end
         wait_for_drain();
      end

      // largest frame: a full-width single row from an oversized width
      apply_setting(2047, 1, 1, 3, 0, 0);
      queue_frame(1);
      wait_for_drain();
      repeat (8) @(posedge clock);

      $display("covered %0d register settings and %0d pixels, %0d boxes checked",
               settings_applied, pixels_accepted, boxes_checked);
      $display("idle mixes 24/83, 83/24 and none, plus one long result hold");
      if (failures == 0 && box_expected.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/abb_pkg.sv
rtl/abb_if.sv
rtl/abb_csr.sv
rtl/active_pixel_bounding_box.sv
rtl/abb_checker.sv
tb/active_pixel_bounding_box_tb.sv
